// File: src/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg
// shared types, status bit positions and codes of the autostart sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package gas_pkg;

    // status bit positions
    localparam int B_ENG     = 0;
    localparam int B_STR     = 1;
    localparam int B_VLV     = 2;
    localparam int B_WARM    = 3;
    localparam int B_COOL    = 4;
    localparam int B_MODE    = 5;
    localparam int B_MANREQ  = 6;
    localparam int B_AUTOREQ = 7;
    localparam int B_AUX     = 8;
    localparam int B_MAINS   = 9;
    localparam int B_WAIT    = 10;
    localparam int B_LOCK    = 11;
    localparam int B_FATAL   = 12;

    localparam logic [12:0] M_ENG   = 13'(1) << B_ENG;
    localparam logic [12:0] M_STR   = 13'(1) << B_STR;
    localparam logic [12:0] M_VLV   = 13'(1) << B_VLV;
    localparam logic [12:0] M_WARM  = 13'(1) << B_WARM;
    localparam logic [12:0] M_COOL  = 13'(1) << B_COOL;
    localparam logic [12:0] M_MAINS = 13'(1) << B_MAINS;
    localparam logic [12:0] M_WAIT  = 13'(1) << B_WAIT;
    localparam logic [12:0] M_SEQ   = M_ENG | M_STR | M_VLV | M_WARM | M_COOL
                                    | M_MAINS | M_WAIT;

    localparam logic [31:0] RETRY_REST_MS = 32'd60000;
    localparam logic [31:0] MS_PER_MIN    = 32'd60000;
    localparam logic [31:0] MS_PER_SEC    = 32'd1000;
    // reciprocal of 100 scaled by 2^23, exact for sums below 91180
    localparam logic [16:0] RECIP_100     = 17'd83887;
    localparam int          RECIP_SHIFT   = 23;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_VALVE   = 2'd1;
    localparam logic [1:0] ERR_START   = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_AUTO_MODE   = 3'd0;
    localparam logic [2:0] CFG_START_BELOW = 3'd1;
    localparam logic [2:0] CFG_STOP_ABOVE  = 3'd2;
    localparam logic [2:0] CFG_WARMUP      = 3'd3;
    localparam logic [2:0] CFG_COOLDOWN    = 3'd4;
    localparam logic [2:0] CFG_MIN_RUN     = 3'd5;
    localparam logic [2:0] CFG_CUR_DROP    = 3'd6;
    localparam logic [2:0] CFG_STARTER_TO  = 3'd7;

    // state codes in match order
    localparam logic [4:0] SC_FATAL    = 5'd0;
    localparam logic [4:0] SC_IDLE     = 5'd1;
    localparam logic [4:0] SC_OPEN     = 5'd2;
    localparam logic [4:0] SC_CRANK_GO = 5'd3;
    localparam logic [4:0] SC_S120     = 5'd4;
    localparam logic [4:0] SC_CRANKING = 5'd5;
    localparam logic [4:0] SC_S130     = 5'd6;
    localparam logic [4:0] SC_S14      = 5'd7;
    localparam logic [4:0] SC_S140     = 5'd8;
    localparam logic [4:0] SC_S15      = 5'd9;
    localparam logic [4:0] SC_S150     = 5'd10;
    localparam logic [4:0] SC_S16      = 5'd11;
    localparam logic [4:0] SC_S160     = 5'd12;
    localparam logic [4:0] SC_WARMUP   = 5'd13;
    localparam logic [4:0] SC_S170     = 5'd14;
    localparam logic [4:0] SC_RUNNING  = 5'd15;
    localparam logic [4:0] SC_S21      = 5'd16;
    localparam logic [4:0] SC_S22      = 5'd17;
    localparam logic [4:0] SC_S220     = 5'd18;
    localparam logic [4:0] SC_S23      = 5'd19;
    localparam logic [4:0] SC_S230     = 5'd20;
    localparam logic [4:0] SC_COOLDOWN = 5'd21;
    localparam logic [4:0] SC_S240     = 5'd22;
    localparam logic [4:0] SC_S241     = 5'd23;
    localparam logic [4:0] SC_S242     = 5'd24;
    localparam logic [4:0] SC_S25      = 5'd25;
    localparam logic [4:0] SC_S250     = 5'd26;
    localparam logic [4:0] SC_REST     = 5'd27;
    localparam logic [4:0] SC_UNKNOWN  = 5'd28;

    typedef struct packed {
        logic        auto_mode;
        logic [15:0] start_below_mv;
        logic [15:0] stop_above_mv;
        logic [15:0] warmup_seconds;
        logic [15:0] cooldown_seconds;
        logic [7:0]  min_run_minutes;
        logic [9:0]  current_drop_threshold;
        logic [15:0] starter_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        engine_running;
        logic        valve_open;
        logic        aux_level;
        logic [15:0] battery_mv;
        logic [9:0]  starter_current;
    } t_item;

    typedef struct packed {
        logic       starter_on;
        logic       mains_on;
        logic       valve_open_pulse;
        logic       valve_close_pulse;
        logic       fatal;
        logic [1:0] error_code;
        logic [4:0] state_code;
    } t_res;

    typedef struct packed {
        logic [12:0] status;
        logic [1:0]  attempts;
        logic [31:0] engine_start;
        logic [31:0] wait_start;
        logic [9:0]  baseline;
        logic [1:0]  error;
    } t_state;

endpackage

`default_nettype wire

// File: src/gas_core.sv
// ----------------------------------------------------------------------------
// gas_core
// one control pass: status refresh, state match and action
// ----------------------------------------------------------------------------
`default_nettype none

module gas_core (
    input  var gas_pkg::t_state i_st,
    input  var gas_pkg::t_cfg   i_cfg,
    input  var gas_pkg::t_item  i_item,
    output var gas_pkg::t_state o_st,
    output var gas_pkg::t_res   o_res
);
    import gas_pkg::*;

    logic [12:0] s;
    logic [1:0]  att;
    logic [1:0]  att_inc;
    logic [31:0] est;
    logic [31:0] wst;
    logic [9:0]  base;
    logic [1:0]  err;
    logic        opn;
    logic        cls;
    logic [4:0]  code;
    logic        edge_fall;
    logic        req;
    logic        z;
    logic [12:0] seq;
    logic [16:0] batt_sum;
    logic [33:0] batt_prod;
    logic [10:0] batt_q;
    logic [16:0] batt_rnd;
    logic [31:0] lock_lim;
    logic [31:0] warm_lim;
    logic [31:0] cool_lim;
    logic [31:0] run_time;
    logic [31:0] wait_time;
    logic [10:0] drop_lim;

    // battery rounding to 100 mV by reciprocal multiply
    assign batt_sum  = {1'b0, i_item.battery_mv} + 17'd50;
    assign batt_prod = 34'(batt_sum) * 34'(RECIP_100);
    assign batt_q    = batt_prod[RECIP_SHIFT +: 11];
    assign batt_rnd  = (17'(batt_q) << 6) + (17'(batt_q) << 5) + (17'(batt_q) << 2);

    // time limits as millisecond thresholds
    assign lock_lim = 32'({1'b0, i_cfg.min_run_minutes} + 9'd1) * MS_PER_MIN;
    assign warm_lim = 32'({1'b0, i_cfg.warmup_seconds} + 17'd1) * MS_PER_SEC;
    assign cool_lim = 32'({1'b0, i_cfg.cooldown_seconds} + 17'd1) * MS_PER_SEC;
    assign drop_lim = {1'b0, i_item.starter_current} + {1'b0, i_cfg.current_drop_threshold};

    always_comb begin
        s    = i_st.status;
        att  = i_st.attempts;
        est  = i_st.engine_start;
        wst  = i_st.wait_start;
        base = i_st.baseline;
        err  = i_st.error;
        opn  = 1'b0;
        cls  = 1'b0;

        // status refresh
        if (s[B_ENG] != i_item.engine_running) begin
            s[B_ENG] = i_item.engine_running;
            if (i_item.engine_running) begin
                est = i_item.now_ms;
                att = 2'd0;
            end else begin
                est = 32'd0;
            end
        end
        s[B_VLV]    = i_item.valve_open;
        edge_fall   = s[B_AUX] & ~i_item.aux_level;
        s[B_AUX]    = i_item.aux_level;
        s[B_MANREQ] = s[B_MANREQ] ^ edge_fall;
        if (batt_rnd < {1'b0, i_cfg.start_below_mv}) s[B_AUTOREQ] = 1'b1;
        if (batt_rnd > {1'b0, i_cfg.stop_above_mv} && !s[B_LOCK]) s[B_AUTOREQ] = 1'b0;
        run_time = i_item.now_ms - est;
        if (s[B_LOCK] && run_time >= lock_lim) s[B_LOCK] = 1'b0;

        req       = i_cfg.auto_mode ? s[B_AUTOREQ] : s[B_MANREQ];
        seq       = s & M_SEQ;
        z         = (att == 2'd0);
        att_inc   = att + 2'd1;
        wait_time = i_item.now_ms - wst;

        // state match and action
        if (s[B_FATAL]) begin
            code = SC_FATAL;
        end else if (seq == 13'd0 && !req) begin
            code = SC_IDLE;
        end else if (seq == 13'd0) begin
            code = SC_OPEN;
            if (att != 2'd3) begin
                opn = 1'b1;
                att = att_inc;
                if (att_inc == 2'd3) s[B_FATAL] = 1'b1;
            end else begin
                s[B_FATAL] = 1'b1;
                err = ERR_VALVE;
            end
        end else if (req && seq == M_VLV) begin
            code       = SC_CRANK_GO;
            att        = 2'd0;
            s[B_STR]   = 1'b1;
            s[B_WAIT]  = 1'b1;
            wst        = i_item.now_ms;
            base       = i_item.starter_current;
        end else if (seq == M_VLV) begin
            code = SC_S120;
            cls  = 1'b1;
        end else if (req && seq == (M_VLV | M_STR | M_WAIT)) begin
            code = SC_CRANKING;
            if ({1'b0, base} > drop_lim) begin
                s[B_STR] = 1'b0;
                att      = 2'd0;
            end else if (wait_time > 32'(i_cfg.starter_timeout_ms)) begin
                s[B_STR]  = 1'b0;
                s[B_WAIT] = 1'b1;
                wst       = i_item.now_ms;
                att       = att_inc;
                if (att_inc == 2'd3) begin
                    s[B_FATAL] = 1'b1;
                    err        = ERR_START;
                end
            end
        end else if (seq == (M_VLV | M_STR | M_WAIT)) begin
            code      = SC_S130;
            s[B_STR]  = 1'b0;
            cls       = 1'b1;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
        end else if (z && req && seq == (M_VLV | M_WAIT)) begin
            code = SC_S14;
        end else if (z && !req && seq == (M_VLV | M_WAIT)) begin
            code      = SC_S140;
            cls       = 1'b1;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
        end else if (z && req && seq == (M_VLV | M_WAIT | M_ENG)) begin
            code      = SC_S15;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
            s[B_WARM] = 1'b1;
            if (i_cfg.auto_mode) s[B_LOCK] = 1'b1;
        end else if (z && seq == (M_VLV | M_WAIT | M_ENG)) begin
            code      = SC_S150;
            cls       = 1'b1;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
        end else if (z && req && seq == (M_VLV | M_ENG | M_WARM)) begin
            code      = SC_S16;
            s[B_WAIT] = 1'b1;
            wst       = i_item.now_ms;
        end else if (z && seq == (M_VLV | M_ENG | M_WARM)) begin
            code      = SC_S160;
            cls       = 1'b1;
            s[B_WARM] = 1'b0;
        end else if (z && req && seq == (M_VLV | M_ENG | M_WARM | M_WAIT)) begin
            code = SC_WARMUP;
            if (wait_time >= warm_lim) begin
                s[B_WAIT]  = 1'b0;
                wst        = 32'd0;
                s[B_WARM]  = 1'b0;
                s[B_MAINS] = 1'b1;
            end
        end else if (z && seq == (M_VLV | M_ENG | M_WARM | M_WAIT)) begin
            code      = SC_S170;
            cls       = 1'b1;
            s[B_WARM] = 1'b0;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
        end else if (z && req && seq == (M_VLV | M_ENG | M_MAINS)) begin
            code = SC_RUNNING;
        end else if (z && seq == (M_VLV | M_ENG | M_MAINS)) begin
            code       = SC_S21;
            s[B_MAINS] = 1'b0;
            s[B_COOL]  = 1'b1;
        end else if (z && !req && seq == (M_VLV | M_ENG)) begin
            code = SC_S22;
        end else if (z && seq == (M_VLV | M_ENG)) begin
            code       = SC_S220;
            s[B_MAINS] = 1'b1;
        end else if (z && !req && seq == (M_VLV | M_ENG | M_COOL)) begin
            code      = SC_S23;
            s[B_WAIT] = 1'b1;
            wst       = i_item.now_ms;
        end else if (z && seq == (M_VLV | M_ENG | M_COOL)) begin
            code       = SC_S230;
            s[B_COOL]  = 1'b0;
            s[B_MAINS] = 1'b1;
        end else if (z && !req && seq == (M_VLV | M_ENG | M_COOL | M_WAIT)) begin
            code = SC_COOLDOWN;
            if (wait_time >= cool_lim) begin
                s[B_COOL] = 1'b0;
                cls       = 1'b1;
                s[B_WAIT] = 1'b0;
                wst       = 32'd0;
            end
        end else if (z && seq == (M_VLV | M_ENG | M_COOL | M_WAIT)) begin
            code       = SC_S240;
            s[B_COOL]  = 1'b0;
            s[B_WAIT]  = 1'b0;
            wst        = 32'd0;
            s[B_MAINS] = 1'b1;
        end else if (z && !req && seq == (M_ENG | M_WAIT)) begin
            code      = SC_S241;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
        end else if (z && !req && seq == (M_WAIT | M_COOL)) begin
            code      = SC_S242;
            s[B_WAIT] = 1'b0;
            wst       = 32'd0;
            s[B_COOL] = 1'b0;
        end else if (z && !req && seq == M_ENG) begin
            code = SC_S25;
        end else if (z && seq == M_ENG) begin
            code = SC_S250;
        end else if (req && !z && seq == (M_VLV | M_WAIT)) begin
            code = SC_REST;
            if (wait_time > RETRY_REST_MS) begin
                s[B_WAIT] = 1'b0;
                wst       = 32'd0;
            end
        end else begin
            // unknown combination: lock up and shut the valve
            code       = SC_UNKNOWN;
            s[B_FATAL] = 1'b1;
            err        = ERR_UNKNOWN;
            s[B_MAINS] = 1'b0;
            s[B_COOL]  = 1'b0;
            s[B_WARM]  = 1'b0;
            cls        = 1'b1;
        end

        o_st.status       = s;
        o_st.attempts     = att;
        o_st.engine_start = est;
        o_st.wait_start   = wst;
        o_st.baseline     = base;
        o_st.error        = err;

        o_res.starter_on        = s[B_STR];
        o_res.mains_on          = s[B_MAINS];
        o_res.valve_open_pulse  = opn;
        o_res.valve_close_pulse = cls;
        o_res.fatal             = s[B_FATAL];
        o_res.error_code        = err;
        o_res.state_code        = code;
    end

endmodule

`default_nettype wire

// File: src/generator_autostart_sequencer.sv
// an input beat passes through the input register and then the result register to its result beat
// throughput: one pass per cycle while the result channel is not stalled; the state feedback
//   loop through the pass logic lets passes follow back to back
// reset (i_rst_n low, synchronous): status, counters, timestamps and error cleared,
//   registers take their default values, both channels empty
// ----------------------------------------------------------------------------
// generator_autostart_sequencer
// supervisory start/stop sequencer for a generator, one control pass per beat
// ----------------------------------------------------------------------------
`default_nettype none

module generator_autostart_sequencer (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // configuration write port
    input  var logic        i_cfg_we,
    input  var logic [2:0]  i_cfg_idx,
    input  var logic [15:0] i_cfg_data,
    // input channel
    input  var logic        i_in_valid,
    output var logic        o_in_ready,
    input  var logic [31:0] i_now_ms,
    input  var logic        i_engine_running,
    input  var logic        i_valve_open,
    input  var logic        i_aux_level,
    input  var logic [15:0] i_battery_mv,
    input  var logic [9:0]  i_starter_current,
    // result channel
    output var logic        o_out_valid,
    input  var logic        i_out_ready,
    output var logic        o_starter_on,
    output var logic        o_mains_on,
    output var logic        o_valve_open_pulse,
    output var logic        o_valve_close_pulse,
    output var logic        o_fatal,
    output var logic [1:0]  o_error_code,
    output var logic [4:0]  o_state_code
);
    import gas_pkg::*;

    t_cfg   r_cfg;
    t_state r_st;
    t_state n_st;
    t_item  r_item;
    t_res   r_res;
    t_res   n_res;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   advance;

    // a pass moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    gas_core u_core (
        .i_st   (r_st),
        .i_cfg  (r_cfg),
        .i_item (r_item),
        .o_st   (n_st),
        .o_res  (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_item.now_ms          <= i_now_ms;
            r_item.engine_running  <= i_engine_running;
            r_item.valve_open      <= i_valve_open;
            r_item.aux_level       <= i_aux_level;
            r_item.battery_mv      <= i_battery_mv;
            r_item.starter_current <= i_starter_current;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // sequencer state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st                         <= '0;
            r_cfg.auto_mode              <= 1'b0;
            r_cfg.start_below_mv         <= 16'd12000;
            r_cfg.stop_above_mv          <= 16'd13800;
            r_cfg.warmup_seconds         <= 16'd120;
            r_cfg.cooldown_seconds       <= 16'd120;
            r_cfg.min_run_minutes        <= 8'd30;
            r_cfg.current_drop_threshold <= 10'd50;
            r_cfg.starter_timeout_ms     <= 16'd5000;
        end else begin
            if (advance) begin
                r_st <= n_st;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AUTO_MODE: begin
                        r_cfg.auto_mode      <= i_cfg_data[0];
                        r_st.status[B_MODE]  <= i_cfg_data[0];
                        if (!i_cfg_data[0]) r_st.status[B_LOCK] <= 1'b0;
                    end
                    CFG_START_BELOW: r_cfg.start_below_mv         <= i_cfg_data;
                    CFG_STOP_ABOVE:  r_cfg.stop_above_mv          <= i_cfg_data;
                    CFG_WARMUP:      r_cfg.warmup_seconds         <= i_cfg_data;
                    CFG_COOLDOWN:    r_cfg.cooldown_seconds       <= i_cfg_data;
                    CFG_MIN_RUN:     r_cfg.min_run_minutes        <= i_cfg_data[7:0];
                    CFG_CUR_DROP:    r_cfg.current_drop_threshold <= i_cfg_data[9:0];
                    CFG_STARTER_TO:  r_cfg.starter_timeout_ms     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // result ports
    assign o_out_valid         = r_out_valid;
    assign o_starter_on        = r_res.starter_on;
    assign o_mains_on          = r_res.mains_on;
    assign o_valve_open_pulse  = r_res.valve_open_pulse;
    assign o_valve_close_pulse = r_res.valve_close_pulse;
    assign o_fatal             = r_res.fatal;
    assign o_error_code        = r_res.error_code;
    assign o_state_code        = r_res.state_code;

endmodule

`default_nettype wire
